@@ hdl/assert_macros.svh @@
// assertion helpers used by the decoder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define AST_IMPL(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define AST_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hdl/usbd_pkg.sv @@
// ----------------------------------------------------------------------------
// usbd_pkg
// shared types, constants and helpers of the unique string block decoder
// ----------------------------------------------------------------------------
package usbd_pkg;

    localparam int BUF_W   = 32;
    localparam int FILL_W  = 6;
    localparam int BC_W    = 10;
    localparam int UC_W    = 8;
    localparam int MAX_RES = 36;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_PACKED = 2'd1;
    localparam logic [1:0] ERR_REF    = 2'd2;

    typedef struct packed {
        logic clr;
        logic load;
        logic take;
    } t_bb_ctrl;

    function automatic logic [3:0] bit_len(input logic [9:0] v);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (v[i]) begin
                r = 4'(i + 1);
            end
        end
        return r;
    endfunction

endpackage

@@ hdl/unique_string_block_decoder_core.sv @@
// ----------------------------------------------------------------------------
// unique_string_block_decoder_core
// decodes one compressed block of unique bytes and string references
// ----------------------------------------------------------------------------
// One request is taken at a time. Block start, header and unique bytes are taken
// in the input state, and a packed header goes to the fail state for its error
// result. A stream byte is appended to the bit buffer, then each code is decided in
// the decision state. A next-unique code then goes straight to its output, and the
// first code gives its two output bytes. Literal, index and copy codes shift all of
// their bits out of the bit buffer one bit per cycle after the decision, then pass
// a check state (which also issues the unique read of an index code), a history
// read state for a copy and one output per decoded byte. A decision that finds too
// few bits returns to the input. Back pressure on the output holds the output and
// fail states. No clearing pass is needed: only memory entries written in the
// current block are read.
`include "assert_macros.svh"

module unique_string_block_decoder_core #(
    parameter int MAX_BLOCK       = 512,
    parameter int INDEXED_UNIQUES = 64,
    parameter int UNIQUE_DEPTH    = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [9:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_block_start,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic [1:0] o_error_code,
    output logic [9:0] o_consumed_count
);

    localparam int CW  = $clog2(MAX_BLOCK + 1);
    localparam int HAW = $clog2(MAX_BLOCK);
    localparam int UAW = $clog2(UNIQUE_DEPTH);
    localparam int FW  = (HAW > 8) ? HAW : 8;
    localparam int PW  = $clog2(FW);
    localparam int SW  = FW + 2;
    localparam int FLW = usbd_pkg::FILL_W;
    localparam int UCW = usbd_pkg::UC_W;
    localparam int BCW = usbd_pkg::BC_W;

    typedef enum logic [2:0] {
        S_IN, S_DEC, S_TAKE, S_AFTER, S_RD, S_EMIT, S_FAIL
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE, PH_COUNT, PH_UNIQ, PH_STREAM, PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        OP_FIRST1, OP_FIRST2, OP_LIT, OP_UNQ, OP_IDX, OP_COPY
    } t_op;

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    t_op              r_op, n_op;
    logic             r_rep, n_rep;
    logic [9:0]       r_orig, n_orig;
    logic [CW-1:0]    r_blen, n_blen;
    logic             r_lb4, n_lb4;
    logic [CW-1:0]    r_ocnt, n_ocnt;
    logic [UCW-1:0]   r_uc, n_uc;
    logic [UCW-1:0]   r_ut, n_ut;
    logic [2:0]       r_iw, n_iw;
    logic [BCW-1:0]   r_bc, n_bc;
    logic [5:0]       r_nres, n_nres;
    logic [FW-1:0]    r_fld, n_fld;
    logic [PW-1:0]    r_fpos, n_fpos;
    logic [2:0]       r_tskip, n_tskip;
    logic [3:0]       r_tcnt, n_tcnt;
    logic [4:0]       r_len, n_len;
    logic [FW-1:0]    r_pos, n_pos;
    logic [1:0]       r_err, n_err;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_last, n_out_last;
    logic [1:0]       r_out_err, n_out_err;
    logic [9:0]       r_out_cons, n_out_cons;

    usbd_pkg::t_bb_ctrl w_bb;
    logic [5:0]         w_peek;
    logic [FLW-1:0]     w_fill;

    logic             w_uwe, w_ure, w_hwe, w_hre;
    logic [UAW-1:0]   w_uwaddr, w_uraddr;
    logic [HAW-1:0]   w_hraddr;
    logic [7:0]       w_uq, w_hq, w_byte;

    logic             w_in_acc, w_out_free, w_last;
    logic [BCW-1:0]   w_used;
    logic [UCW-1:0]   w_avail;
    logic [3:0]       w_pbits;
    logic [3:0]       w_uclen;
    logic [4:0]       w_clen;
    logic [FLW-1:0]   w_cneed, w_ineed;
    logic [CW-1:0]    w_ocnt_inc, w_clamp;
    logic [FW-1:0]    w_pos_nx;

    usbd_bitbuf u_bitbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_bb),
        .i_byte  (i_in_byte),
        .o_peek  (w_peek),
        .o_fill  (w_fill)
    );

    usbd_ram #(.WIDTH(8), .DEPTH(UNIQUE_DEPTH)) u_uniq_ram (
        .i_clk   (i_clk),
        .i_we    (w_uwe),
        .i_waddr (w_uwaddr),
        .i_wdata (i_in_byte),
        .i_re    (w_ure),
        .i_raddr (w_uraddr),
        .o_rdata (w_uq)
    );

    usbd_ram #(.WIDTH(8), .DEPTH(MAX_BLOCK)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hwe),
        .i_waddr (r_ocnt[HAW-1:0]),
        .i_wdata (w_byte),
        .i_re    (w_hre),
        .i_raddr (w_hraddr),
        .o_rdata (w_hq)
    );

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_used     = r_bc - BCW'(w_fill[FLW-1:3]);
    assign w_avail    = (r_ut < UCW'(UNIQUE_DEPTH)) ? r_ut : UCW'(UNIQUE_DEPTH);
    assign w_pbits    = usbd_pkg::bit_len(10'(r_ocnt));
    assign w_uclen    = usbd_pkg::bit_len(10'(r_uc));
    assign w_clen     = (r_lb4 ? 5'(w_peek[5:2]) : 5'(w_peek[4:2])) + 5'd2;
    assign w_cneed    = FLW'(2) + (r_lb4 ? FLW'(4) : FLW'(3)) + FLW'(w_pbits);
    assign w_ineed    = FLW'(2) + FLW'(r_iw);
    assign w_ocnt_inc = r_ocnt + CW'(1);
    assign w_last     = (w_ocnt_inc >= r_blen);
    assign w_pos_nx   = r_pos + FW'(1);
    assign w_byte     = (r_op == OP_LIT) ? r_fld[7:0] : ((r_op == OP_COPY) ? w_hq : w_uq);

    always_comb begin
        if (r_orig < 10'd3) begin
            w_clamp = CW'(3);
        end else if (r_orig > 10'(MAX_BLOCK)) begin
            w_clamp = CW'(MAX_BLOCK);
        end else begin
            w_clamp = CW'(r_orig);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_op        = r_op;
        n_rep       = r_rep;
        n_orig      = r_orig;
        n_blen      = r_blen;
        n_lb4       = r_lb4;
        n_ocnt      = r_ocnt;
        n_uc        = r_uc;
        n_ut        = r_ut;
        n_iw        = r_iw;
        n_bc        = r_bc;
        n_nres      = r_nres;
        n_fld       = r_fld;
        n_fpos      = r_fpos;
        n_tskip     = r_tskip;
        n_tcnt      = r_tcnt;
        n_len       = r_len;
        n_pos       = r_pos;
        n_err       = r_err;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        n_out_cons  = r_out_cons;
        w_bb        = '0;
        w_uwe       = 1'b0;
        w_uwaddr    = r_uc[UAW-1:0];
        w_ure       = 1'b0;
        w_uraddr    = '0;
        w_hwe       = 1'b0;
        w_hre       = 1'b0;
        w_hraddr    = r_pos[HAW-1:0];

        if (i_cfg_we) begin
            n_orig = i_cfg_data;
        end

        case (r_state)
            S_IN: begin
                if (w_in_acc) begin
                    n_nres = '0;
                    if (i_block_start) begin
                        n_phase  = PH_COUNT;
                        w_bb.clr = 1'b1;
                        n_ocnt   = '0;
                        n_uc     = '0;
                        n_ut     = '0;
                        n_iw     = 3'd1;
                        n_bc     = BCW'(1);
                        n_blen   = w_clamp;
                        n_lb4    = (w_clamp > CW'(64));
                    end else if (r_phase != PH_IDLE && r_phase != PH_DONE) begin
                        if (r_bc < BCW'(1023)) begin
                            n_bc = r_bc + BCW'(1);
                        end
                        case (r_phase)
                            PH_COUNT: begin
                                if (i_in_byte[7]) begin
                                    n_err   = usbd_pkg::ERR_PACKED;
                                    n_state = S_FAIL;
                                end else begin
                                    n_ut    = UCW'(i_in_byte[6:0]) + UCW'(1);
                                    n_uc    = '0;
                                    n_phase = PH_UNIQ;
                                end
                            end
                            PH_UNIQ: begin
                                w_uwe = (r_uc < UCW'(UNIQUE_DEPTH));
                                n_uc  = r_uc + UCW'(1);
                                if (r_uc + UCW'(1) >= r_ut) begin
                                    n_uc     = '0;
                                    w_bb.clr = 1'b1;
                                    n_phase  = PH_STREAM;
                                end
                            end
                            default: begin
                                w_bb.load = 1'b1;
                                n_state   = S_DEC;
                            end
                        endcase
                    end
                end
            end
            S_DEC: begin
                n_fld  = '0;
                n_fpos = '0;
                n_rep  = 1'b0;
                if (r_phase != PH_STREAM) begin
                    n_state = S_IN;
                end else if (r_ocnt == '0) begin
                    // first code: repeat flag for output 1
                    if (w_fill < FLW'(1) || r_nres > 6'd34) begin
                        n_state = S_IN;
                    end else begin
                        w_bb.take = 1'b1;
                        n_iw      = 3'd1;
                        if (w_peek[0]) begin
                            w_ure   = 1'b1;
                            n_op    = OP_FIRST1;
                            n_uc    = UCW'(1);
                            n_state = S_EMIT;
                        end else if (w_avail < UCW'(2)) begin
                            n_err   = usbd_pkg::ERR_REF;
                            n_state = S_FAIL;
                        end else begin
                            w_ure   = 1'b1;
                            n_op    = OP_FIRST2;
                            n_uc    = UCW'(2);
                            n_state = S_EMIT;
                        end
                    end
                end else if (w_ocnt_inc >= r_blen) begin
                    // final byte is a plain literal
                    if (w_fill < FLW'(8) || r_nres > 6'd35) begin
                        n_state = S_IN;
                    end else begin
                        n_op    = OP_LIT;
                        n_tskip = 3'd0;
                        n_tcnt  = 4'd8;
                        n_state = S_TAKE;
                    end
                end else if (!w_peek[0]) begin
                    if (w_fill < FLW'(1) || r_nres > 6'd35) begin
                        n_state = S_IN;
                    end else begin
                        w_bb.take = 1'b1;
                        if (r_uc >= w_avail) begin
                            n_err   = usbd_pkg::ERR_REF;
                            n_state = S_FAIL;
                        end else begin
                            w_ure    = 1'b1;
                            w_uraddr = r_uc[UAW-1:0];
                            if (r_uc < UCW'(INDEXED_UNIQUES)) begin
                                n_iw = w_uclen[2:0];
                            end
                            n_uc    = r_uc + UCW'(1);
                            n_op    = OP_UNQ;
                            n_state = S_EMIT;
                        end
                    end
                end else if (w_fill < FLW'(2)) begin
                    n_state = S_IN;
                end else if (!w_peek[1]) begin
                    if (w_fill < w_ineed || r_nres > 6'd35) begin
                        n_state = S_IN;
                    end else begin
                        n_op    = OP_IDX;
                        n_tskip = 3'd2;
                        n_tcnt  = 4'(r_iw);
                        n_state = S_TAKE;
                    end
                end else begin
                    if (w_fill < w_cneed || 7'(r_nres) + 7'(w_clen) > 7'(usbd_pkg::MAX_RES))
                    begin
                        n_state = S_IN;
                    end else begin
                        n_op    = OP_COPY;
                        n_len   = w_clen;
                        n_tskip = r_lb4 ? 3'd6 : 3'd5;
                        n_tcnt  = w_pbits;
                        n_state = S_TAKE;
                    end
                end
            end
            S_TAKE: begin
                w_bb.take = 1'b1;
                if (r_tskip != 3'd0) begin
                    n_tskip = r_tskip - 3'd1;
                end else begin
                    n_fld[r_fpos] = w_peek[0];
                    n_fpos        = r_fpos + PW'(1);
                    n_tcnt        = r_tcnt - 4'd1;
                    if (r_tcnt == 4'd1) begin
                        n_state = S_AFTER;
                    end
                end
            end
            S_AFTER: begin
                case (r_op)
                    OP_IDX: begin
                        if (10'(r_fld) >= 10'(w_avail)) begin
                            n_err   = usbd_pkg::ERR_REF;
                            n_state = S_FAIL;
                        end else begin
                            w_ure    = 1'b1;
                            w_uraddr = r_fld[UAW-1:0];
                            n_state  = S_EMIT;
                        end
                    end
                    OP_COPY: begin
                        if (SW'(r_fld) + SW'(r_len) > SW'(r_ocnt) ||
                            SW'(r_ocnt) + SW'(r_len) > SW'(r_blen)) begin
                            n_err   = usbd_pkg::ERR_REF;
                            n_state = S_FAIL;
                        end else begin
                            n_pos   = r_fld;
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_RD: begin
                w_hre   = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_hwe       = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_byte  = w_byte;
                    n_out_last  = w_last;
                    n_out_err   = usbd_pkg::ERR_OK;
                    n_out_cons  = w_last ? w_used : '0;
                    n_ocnt      = w_ocnt_inc;
                    n_nres      = r_nres + 6'd1;
                    n_state     = S_DEC;
                    if (w_last) begin
                        n_phase = PH_DONE;
                        n_state = S_IN;
                    end else begin
                        case (r_op)
                            OP_FIRST1: begin
                                if (!r_rep) begin
                                    n_rep   = 1'b1;
                                    n_state = S_EMIT;
                                end
                            end
                            OP_FIRST2: begin
                                if (!r_rep) begin
                                    n_rep    = 1'b1;
                                    w_ure    = 1'b1;
                                    w_uraddr = UAW'(1);
                                    n_state  = S_EMIT;
                                end
                            end
                            OP_COPY: begin
                                n_pos = w_pos_nx;
                                n_len = r_len - 5'd1;
                                if (r_len > 5'd1) begin
                                    w_hre    = 1'b1;
                                    w_hraddr = w_pos_nx[HAW-1:0];
                                    n_state  = S_EMIT;
                                end
                            end
                            default: begin
                                n_state = S_DEC;
                            end
                        endcase
                    end
                end
            end
            S_FAIL: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = '0;
                    n_out_last  = 1'b1;
                    n_out_err   = r_err;
                    n_out_cons  = w_used;
                    n_nres      = r_nres + 6'd1;
                    n_phase     = PH_DONE;
                    n_state     = S_IN;
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IN;
            r_phase     <= PH_IDLE;
            r_op        <= OP_LIT;
            r_rep       <= 1'b0;
            r_orig      <= 10'd512;
            r_blen      <= CW'(MAX_BLOCK);
            r_lb4       <= 1'b1;
            r_ocnt      <= '0;
            r_uc        <= '0;
            r_ut        <= '0;
            r_iw        <= 3'd1;
            r_bc        <= '0;
            r_nres      <= '0;
            r_fld       <= '0;
            r_fpos      <= '0;
            r_tskip     <= '0;
            r_tcnt      <= '0;
            r_len       <= '0;
            r_pos       <= '0;
            r_err       <= usbd_pkg::ERR_OK;
            r_out_valid <= 1'b0;
            r_out_byte  <= '0;
            r_out_last  <= 1'b0;
            r_out_err   <= usbd_pkg::ERR_OK;
            r_out_cons  <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_op        <= n_op;
            r_rep       <= n_rep;
            r_orig      <= n_orig;
            r_blen      <= n_blen;
            r_lb4       <= n_lb4;
            r_ocnt      <= n_ocnt;
            r_uc        <= n_uc;
            r_ut        <= n_ut;
            r_iw        <= n_iw;
            r_bc        <= n_bc;
            r_nres      <= n_nres;
            r_fld       <= n_fld;
            r_fpos      <= n_fpos;
            r_tskip     <= n_tskip;
            r_tcnt      <= n_tcnt;
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            r_out_byte  <= n_out_byte;
            r_out_last  <= n_out_last;
            r_out_err   <= n_out_err;
            r_out_cons  <= n_out_cons;
        end
    end

    assign o_in_stall       = (r_state != S_IN);
    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_out_last       = r_out_last;
    assign o_error_code     = r_out_err;
    assign o_consumed_count = r_out_cons;

    `AST_IMPL(a_take_nonempty, r_state == S_TAKE, w_fill != '0, "bit taken from empty buffer")
    `AST_IMPL(a_res_limit, 1'b1, r_nres <= 6'(usbd_pkg::MAX_RES), "too many results per request")
    `AST_IMPL(a_ocnt_range, 1'b1, r_ocnt <= r_blen, "output count past block length")
    `AST_NEXT(a_start_phase, w_in_acc && i_block_start, r_phase == PH_COUNT, "block start lost")

endmodule

@@ hdl/usbd_ram.sv @@
// ----------------------------------------------------------------------------
// usbd_ram
// generic ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module usbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

@@ hdl/usbd_bitbuf.sv @@
// ----------------------------------------------------------------------------
// usbd_bitbuf
// stream bit buffer, bytes appended at the fill level, bits leave one a cycle on take
// ----------------------------------------------------------------------------
module usbd_bitbuf (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  usbd_pkg::t_bb_ctrl               i_ctrl,
    input  logic [7:0]                       i_byte,
    output logic [5:0]                       o_peek,
    output logic [usbd_pkg::FILL_W-1:0]      o_fill
);

    logic [usbd_pkg::BUF_W-1:0]  r_buf, n_buf;
    logic [usbd_pkg::FILL_W-1:0] r_fill, n_fill;

    always_comb begin
        n_buf  = r_buf;
        n_fill = r_fill;
        if (i_ctrl.clr) begin
            n_buf  = '0;
            n_fill = '0;
        end else if (i_ctrl.load) begin
            // bytes past a fill of 24 are dropped
            if (r_fill <= 6'd24) begin
                n_buf  = r_buf | (usbd_pkg::BUF_W'(i_byte) << r_fill[4:0]);
                n_fill = r_fill + 6'd8;
            end
        end else if (i_ctrl.take) begin
            n_buf  = r_buf >> 1;
            n_fill = r_fill - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= '0;
            r_fill <= '0;
        end else begin
            r_buf  <= n_buf;
            r_fill <= n_fill;
        end
    end

    assign o_peek = r_buf[5:0];
    assign o_fill = r_fill;

endmodule

@@ tb/unique_string_block_decoder_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_string_block_decoder_core_test
// drives compressed blocks (well-formed, broken and noise bytes) through the
// decoder under random stalls and checks every decoded byte against a
// built-in predictor of the decoder
// ----------------------------------------------------------------------------
module unique_string_block_decoder_core_test;

    localparam int BLOCK_MAX  = 512;
    localparam int IDX_UNIQ   = 64;
    localparam int UNIQ_DEPTH = 128;
    localparam int CYCLE_CAP  = 400000;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic [1:0] err;
        logic [9:0] used;
    } t_byte_exp;

    class decode_scoreboard;
        logic [7:0] hist [BLOCK_MAX];
        logic [7:0] uniq [UNIQ_DEPTH];
        typedef enum int {ST_IDLE, ST_COUNT, ST_UNIQ, ST_STREAM, ST_DONE} t_phase;
        t_phase     ph;
        int unsigned bbuf, bfill, outn, ucnt, utotal, iwidth, bcnt, cfg_len, blen;
        int          nres;
        t_byte_exp  exp_q[$];
        int         mismatches, results, requests, errors;

        function new();
            ph = ST_IDLE; bbuf = 0; bfill = 0; outn = 0; ucnt = 0; utotal = 0;
            iwidth = 1; bcnt = 0; cfg_len = 512; blen = 512;
        endfunction

        function int unsigned blen_of(int unsigned v);
            int unsigned r;
            r = 0;
            while (v != 0) begin
                r++;
                v >>= 1;
            end
            return r;
        endfunction

        function int unsigned used_bytes();
            int unsigned c;
            c = bcnt - (bfill >> 3);
            return c > 1023 ? 1023 : c;
        endfunction

        function void push(logic [7:0] d, logic l, logic [1:0] e, int unsigned u);
            t_byte_exp x;
            if (nres >= usbd_pkg::MAX_RES) return;
            x.data = d; x.last = l; x.err = e; x.used = u[9:0];
            exp_q.push_back(x);
            nres++;
        endfunction

        function void emit(logic [7:0] d);
            bit l;
            if (outn < BLOCK_MAX) hist[outn] = d;
            outn++;
            l = outn >= blen;
            push(d, l, usbd_pkg::ERR_OK, l ? used_bytes() : 0);
            if (l) ph = ST_DONE;
        endfunction

        function void fail(logic [1:0] e);
            push(8'd0, 1'b1, e, used_bytes());
            errors++;
            ph = ST_DONE;
        endfunction

        function void take(int unsigned n);
            bbuf = n >= 32 ? 0 : bbuf >> n;
            bfill -= n;
        endfunction

        function int unsigned avail();
            return utotal < UNIQ_DEPTH ? utotal : UNIQ_DEPTH;
        endfunction

        function void run_stream();
            int unsigned lb, need, idx, len, pos, pb;
            lb = blen <= 64 ? 3 : 4;
            while (ph == ST_STREAM) begin
                if (outn == 0) begin
                    if (bfill < 1 || nres + 2 > usbd_pkg::MAX_RES) return;
                    if (bbuf[0]) begin
                        emit(uniq[0]); emit(uniq[0]); ucnt = 1;
                    end else begin
                        if (avail() < 2) begin
                            take(1); fail(usbd_pkg::ERR_REF); return;
                        end
                        emit(uniq[0]); emit(uniq[1]); ucnt = 2;
                    end
                    take(1);
                    iwidth = 1;
                end else if (outn + 1 >= blen) begin
                    if (bfill < 8 || nres + 1 > usbd_pkg::MAX_RES) return;
                    idx = bbuf & 8'hff;
                    take(8);
                    emit(idx[7:0]);
                end else if (!bbuf[0]) begin
                    if (bfill < 1 || nres + 1 > usbd_pkg::MAX_RES) return;
                    take(1);
                    if (ucnt >= avail()) begin
                        fail(usbd_pkg::ERR_REF); return;
                    end
                    emit(uniq[ucnt]);
                    if (ucnt < IDX_UNIQ) iwidth = blen_of(ucnt) & 7;
                    ucnt++;
                end else begin
                    if (bfill < 2) return;
                    if (!bbuf[1]) begin
                        need = 2 + iwidth;
                        if (bfill < need || nres + 1 > usbd_pkg::MAX_RES) return;
                        idx = (bbuf >> 2) & ((1 << iwidth) - 1);
                        take(need);
                        if (idx >= avail()) begin
                            fail(usbd_pkg::ERR_REF); return;
                        end
                        emit(uniq[idx]);
                    end else begin
                        pb = blen_of(outn);
                        need = 2 + lb + pb;
                        if (bfill < need) return;
                        len = ((bbuf >> 2) & ((1 << lb) - 1)) + 2;
                        pos = (bbuf >> (2 + lb)) & ((1 << pb) - 1);
                        if (nres + len > usbd_pkg::MAX_RES) return;
                        take(need);
                        if (pos + len > outn || outn + len > blen) begin
                            fail(usbd_pkg::ERR_REF); return;
                        end
                        for (int k = 0; k < len && ph == ST_STREAM; k++) begin
                            emit(pos + k < BLOCK_MAX ? hist[pos + k] : 8'd0);
                        end
                    end
                end
            end
        endfunction

        function void note_request(logic [7:0] b, logic st);
            requests++;
            nres = 0;
            if (st) begin
                ph = ST_COUNT; bbuf = 0; bfill = 0; outn = 0; ucnt = 0; utotal = 0;
                iwidth = 1; bcnt = 1;
                blen = cfg_len < 3 ? 3 : (cfg_len > BLOCK_MAX ? BLOCK_MAX : cfg_len);
                return;
            end
            if (ph == ST_IDLE || ph == ST_DONE) return;
            if (bcnt < 1023) bcnt++;
            case (ph)
                ST_COUNT: begin
                    if (b[7]) begin
                        fail(usbd_pkg::ERR_PACKED);
                    end else begin
                        utotal = b[6:0] + 1; ucnt = 0; ph = ST_UNIQ;
                    end
                end
                ST_UNIQ: begin
                    if (ucnt < UNIQ_DEPTH) uniq[ucnt] = b;
                    ucnt++;
                    if (ucnt >= utotal) begin
                        ucnt = 0; bbuf = 0; bfill = 0; ph = ST_STREAM;
                    end
                end
                default: begin
                    if (bfill <= 24) begin
                        bbuf |= int'(b) << bfill;
                        bfill += 8;
                    end
                    run_stream();
                end
            endcase
        endfunction

        function void check_result(logic [7:0] d, logic l, logic [1:0] e, logic [9:0] u);
            t_byte_exp x;
            results++;
            if (exp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output byte %02h last %0b", d, l);
                return;
            end
            x = exp_q.pop_front();
            if (d !== x.data || l !== x.last || e !== x.err || u !== x.used) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp byte %02h last %0b err %0d used %0d, got %02h %0b %0d %0d",
                             x.data, x.last, x.err, x.used, d, l, e, u);
            end
        endfunction
    endclass

    logic       i_clk, i_rst_n, i_cfg_we, i_in_valid, i_block_start, i_out_stall;
    logic [9:0] i_cfg_data;
    logic [7:0] i_in_byte;
    logic       o_in_stall, o_out_valid, o_out_last;
    logic [7:0] o_out_byte;
    logic [1:0] o_error_code;
    logic [9:0] o_consumed_count;

    decode_scoreboard sb;
    int  cycles, blocks;
    bit  no_gaps, hold_req;

    unique_string_block_decoder_core u_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_in_valid, .o_in_stall,
        .i_in_byte, .i_block_start, .o_out_valid, .i_out_stall, .o_out_byte,
        .o_out_last, .o_error_code, .o_consumed_count
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_request(i_in_byte, i_block_start);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_byte, o_out_last, o_error_code, o_consumed_count);
    end

    // receiver: random stalls, one long hold on request
    initial begin
        int gap;
        bit acc;
        i_out_stall = 1'b1;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
            end
            gap = no_gaps ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                acc = o_out_valid;
                @(posedge i_clk);
            end while (!acc);
        end
    end

    task automatic send_byte(logic [7:0] b, logic st);
        int gap;
        bit acc;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_byte     <= b;
        i_block_start <= st;
        do begin
            @(negedge i_clk);
            acc = !o_in_stall;
            @(posedge i_clk);
        end while (!acc);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_length(logic [9:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.cfg_len = v;
    endtask

    task automatic send_bytes(logic [7:0] q[$]);
        blocks++;
        foreach (q[i]) send_byte(q[i], i == 0);
    endtask

    // builds a well-formed block for the current length setting
    function automatic void build_block(int unsigned u, output logic [7:0] q[$]);
        bit          bits[$];
        int unsigned n, outn, ucnt, iw, lb, mx, sel, len, pos, idx, pb, lim;
        logic [7:0]  v;
        n  = sb.cfg_len < 3 ? 3 : (sb.cfg_len > BLOCK_MAX ? BLOCK_MAX : sb.cfg_len);
        lb = n <= 64 ? 3 : 4;
        q = {};
        q.push_back(8'($urandom));
        q.push_back(8'(u - 1));
        repeat (u) q.push_back(8'($urandom));
        bits.push_back(u < 2 ? 1'b1 : 1'($urandom));
        ucnt = bits[0] ? 1 : 2;
        outn = 2;
        iw = 1;
        while (outn + 1 < n) begin
            sel = $urandom_range(0, 2);
            if (sel == 0 && ucnt >= u) sel = 1;
            if (sel == 2 && (outn < 2 || n - outn < 2)) sel = 1;
            if (n > 64 && outn >= 2 && n - outn >= 2 && $urandom_range(0, 1)) sel = 2;
            if (sel == 0) begin
                bits.push_back(1'b0);
                if (ucnt < IDX_UNIQ) iw = sb.blen_of(ucnt) & 7;
                ucnt++;
                outn++;
            end else if (sel == 1) begin
                bits.push_back(1'b1); bits.push_back(1'b0);
                lim = u < (1 << iw) ? u : (1 << iw);
                idx = $urandom_range(0, lim - 1);
                for (int k = 0; k < iw; k++) bits.push_back(idx[k]);
                outn++;
            end else begin
                mx = lb == 3 ? 9 : 17;
                if (mx > n - outn) mx = n - outn;
                if (mx > outn) mx = outn;
                len = $urandom_range(2, mx);
                pos = $urandom_range(0, outn - len);
                pb = sb.blen_of(outn);
                bits.push_back(1'b1); bits.push_back(1'b1);
                for (int k = 0; k < lb; k++) bits.push_back(1'((len - 2) >> k));
                for (int k = 0; k < pb; k++) bits.push_back(pos[k]);
                outn += len;
            end
        end
        if (outn + 1 == n) begin
            v = 8'($urandom);
            for (int k = 0; k < 8; k++) bits.push_back(v[k]);
        end
        while (bits.size() % 8 != 0) bits.push_back(1'($urandom));
        for (int i = 0; i < bits.size(); i += 8) begin
            for (int k = 0; k < 8; k++) v[k] = bits[i + k];
            q.push_back(v);
        end
    endfunction

    initial begin
        logic [7:0] q[$];
        int unsigned pick;
        sb = new();
        cycles = 0; blocks = 0; no_gaps = 0; hold_req = 0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_data = 0; i_in_valid = 0;
        i_in_byte = 0; i_block_start = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bytes before any block start are dropped
        send_byte(8'hff, 0);
        send_byte(8'h00, 0);
        set_length(10'd3);
        send_bytes('{8'h00, 8'h00, 8'hff, 8'h01, 8'h00});
        send_bytes('{8'hff, 8'h01, 8'h00, 8'hff, 8'h00, 8'hfe, 8'h01});
        send_byte(8'h55, 0);
        send_bytes('{8'h00, 8'h80});
        send_bytes('{8'h00, 8'hff});
        send_bytes('{8'h00, 8'h00, 8'h41, 8'h00});
        set_length(10'd0);
        send_bytes('{8'h12, 8'h01, 8'h61, 8'h62, 8'h07});
        set_length(10'd8);
        send_bytes('{8'h00, 8'h01, 8'h61, 8'h62, 8'hfe, 8'hff});

        while (sb.requests < 95) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: set_length(10'd3);
                1, 2: set_length(10'($urandom_range(65, 100)));
                default: if ($urandom_range(0, 1)) set_length(10'($urandom_range(4, 40)));
            endcase
            no_gaps = $urandom_range(0, 3) == 0;
            if (blocks == 8) hold_req = 1;
            build_block($urandom_range(1, 12), q);
            if ($urandom_range(0, 5) == 0) begin
                // broken stream: replace random payload bytes with random values
                foreach (q[i])
                    if (i > 1 + q[1] + 1 && $urandom_range(0, 3) == 0) q[i] = 8'($urandom);
            end
            if ($urandom_range(0, 9) == 0) q[1] = q[1] | 8'h80;
            send_bytes(q);
            if ($urandom_range(0, 3) == 0) send_byte(8'($urandom), 0);
            if ($urandom_range(0, 7) == 0) drain();
        end
        no_gaps = 0;
        drain();
        repeat (100) @(posedge i_clk);
        $display("ran %0d blocks from %0d input bytes at several block lengths",
                 blocks, sb.requests);
        $display("checked %0d decoded bytes, %0d of them error results",
                 sb.results, sb.errors);
        if (sb.mismatches == 0 && sb.exp_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ unique_string_block_decoder_core.f @@
+incdir+hdl
hdl/usbd_pkg.sv
hdl/usbd_ram.sv
hdl/usbd_bitbuf.sv
hdl/unique_string_block_decoder_core.sv
tb/unique_string_block_decoder_core_test.sv
